// ----- design/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg - shared types and constants for stream_find_replace
// Register indexes, default size limits, the per-cell control group and burst flags.
// ----------------------------------------------------------------------------
package sfr_pkg;

	// default size limits, in bytes
	localparam int unsigned MaxPatternBytes = 8;
	localparam int unsigned MaxReplaceBytes = 8;

	// configuration register fields
	localparam int unsigned CfgDataW = 64;
	localparam int unsigned CfgLenW  = 4;
	localparam int unsigned CfgIdxW  = 2;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_PATTERN_BYTES      = 2'd0,
		CFG_PATTERN_LENGTH     = 2'd1,
		CFG_REPLACEMENT_BYTES  = 2'd2,
		CFG_REPLACEMENT_LENGTH = 2'd3
	} cfg_idx_t;

	// control shared by every window cell
	typedef struct packed {
		logic upd;    // an item enters the window this cycle
		logic shift;  // drop the oldest byte, take the neighbor's byte
	} cell_ctl_t;

	// flags of a staged burst of result items
	typedef struct packed {
		logic last;   // the final item of the burst closes the string
		logic empty;  // the burst is a single end mark without a byte
	} burst_flags_t;

endpackage

// ----- design/sfr_if.sv -----
// ----------------------------------------------------------------------------
// sfr_if - valid/ready channels of stream_find_replace
// Input channel carries source bytes, output channel rewritten bytes.
// ----------------------------------------------------------------------------
interface sfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface sfr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_empty;
	logic       out_last;

	modport source (output valid, output out_byte, output out_empty, output out_last,
		input ready);
	modport sink   (input valid, input out_byte, input out_empty, input out_last,
		output ready);
endinterface

// ----- design/sfr_cell.sv -----
// ----------------------------------------------------------------------------
// sfr_cell - one byte slot of the match window
// Holds one window byte, compares it with its pattern byte, hands it on.
// ----------------------------------------------------------------------------
module sfr_cell
	import sfr_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      wr,         // the incoming byte lands in this slot
	input  logic      active,     // slot lies inside the pattern length
	input  logic [7:0] new_byte,
	input  logic [7:0] pat_byte,
	input  logic [7:0] nxt_byte,  // updated byte of the younger neighbor
	input  logic      match_in,
	output logic [7:0] cur_byte,  // this slot's byte including the new item
	output logic      match_out
);

	logic [7:0] byte_q;

	assign cur_byte  = wr ? new_byte : byte_q;
	assign match_out = match_in & (~active | (cur_byte == pat_byte));

	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			byte_q <= ctl.shift ? nxt_byte : cur_byte;
		end
	end

endmodule

// ----- design/sfr_emit.sv -----
// ----------------------------------------------------------------------------
// sfr_emit - result staging and output register
// Holds one staged burst and one burst in delivery, one item per cycle if ready.
// ----------------------------------------------------------------------------
module sfr_emit
	import sfr_pkg::*;
#(
	parameter int unsigned BurstBytes = MaxPatternBytes
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         ld_valid,
	output logic                         ld_ready,
	input  logic [8*BurstBytes-1:0]      ld_data,
	input  logic [$clog2(BurstBytes+1)-1:0] ld_cnt,
	input  burst_flags_t                 ld_flags,
	sfr_out_if.source                    out_ch
);

	localparam int unsigned BW = $clog2(BurstBytes + 1);

	logic                    nb_valid_q;
	logic [8*BurstBytes-1:0] nb_data_q;
	logic [BW-1:0]           nb_cnt_q;
	burst_flags_t            nb_flags_q;

	logic [8*BurstBytes-1:0] ob_data_q;
	logic [BW-1:0]           ob_cnt_q;
	burst_flags_t            ob_flags_q;

	logic out_acc;
	logic ob_drain;
	logic move;

	assign out_acc  = out_ch.valid & out_ch.ready;
	assign ob_drain = (ob_cnt_q == '0) | ((ob_cnt_q == BW'(1)) & out_acc);
	assign move     = ob_drain & nb_valid_q;
	// take a new burst when the stage is empty or hands its burst on now
	assign ld_ready = ~nb_valid_q | move;

	assign out_ch.valid     = (ob_cnt_q != '0);
	assign out_ch.out_byte  = ob_data_q[7:0];
	assign out_ch.out_empty = ob_flags_q.empty;
	assign out_ch.out_last  = ob_flags_q.last & (ob_cnt_q == BW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_valid_q <= 1'b0;
			ob_cnt_q   <= '0;
		end else begin
			if (ld_valid & ld_ready) begin
				nb_valid_q <= 1'b1;
			end else if (move) begin
				nb_valid_q <= 1'b0;
			end
			if (move) begin
				ob_cnt_q <= nb_cnt_q;
			end else if (out_acc) begin
				ob_cnt_q <= ob_cnt_q - BW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_valid & ld_ready) begin
			nb_data_q  <= ld_data;
			nb_cnt_q   <= ld_cnt;
			nb_flags_q <= ld_flags;
		end
		if (move) begin
			ob_data_q  <= nb_data_q;
			ob_flags_q <= nb_flags_q;
		end else if (out_acc) begin
			ob_data_q <= ob_data_q >> 8;
		end
	end

endmodule

// ----- design/stream_find_replace.sv -----
// ----------------------------------------------------------------------------
// stream_find_replace - streaming byte find-and-replace
// Rewrites a byte stream, replacing each occurrence of a pattern.
// ----------------------------------------------------------------------------
// Bytes enter one item per cycle on in_ch, with in_last on the final byte of
// a string. Every leftmost, non-overlapping occurrence of the pattern (up to
// MAX_PATTERN_BYTES bytes, set by pattern_bytes / pattern_length) is replaced
// by the replacement (up to MAX_REPLACE_BYTES bytes, replacement_length of
// zero deletes matches). A pattern length of zero passes bytes through.
// The window is a row of cells, one byte each; every cell compares its byte
// with its pattern byte, and the match result ripples down the row in the
// same cycle an item arrives. The results of one input item form a burst:
// one burst is staged while the previous one drains from the output register,
// one result per cycle while out_ch is ready. Rate: one input item per cycle
// while each item yields at most one result and out_ch is not stalled; an
// item that yields k results (a replacement or the flush at end of string)
// holds the input while the single output port drains the burst. An end of
// string that leaves no byte produces one item with out_empty set. The user
// must write configuration through cfg_we / cfg_index / cfg_data only while the
// block is idle (unenforced); writing the pattern length empties the window.
// ----------------------------------------------------------------------------
module stream_find_replace
	import sfr_pkg::*;
#(
	parameter int unsigned MAX_PATTERN_BYTES = MaxPatternBytes,
	parameter int unsigned MAX_REPLACE_BYTES = MaxReplaceBytes
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	sfr_in_if.sink              in_ch,
	sfr_out_if.source           out_ch
);

	localparam int unsigned CW = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int unsigned RW = $clog2(MAX_REPLACE_BYTES + 1);
	localparam int unsigned BB = (MAX_PATTERN_BYTES > MAX_REPLACE_BYTES) ?
		MAX_PATTERN_BYTES : MAX_REPLACE_BYTES;
	localparam int unsigned BW = $clog2(BB + 1);

	// configuration registers
	logic [CfgDataW-1:0] pat_bytes_q;
	logic [CfgLenW-1:0]  pat_len_q;
	logic [CfgDataW-1:0] rep_bytes_q;
	logic [CfgLenW-1:0]  rep_len_q;

	// window fill level
	logic [CW-1:0] cnt_q;

	logic [CW-1:0] pl_eff;
	logic [RW-1:0] rl_eff;
	logic          accept;
	logic          full;
	logic          match;
	cell_ctl_t     ctl;

	logic [7:0] cur [MAX_PATTERN_BYTES];
	logic       mchain [MAX_PATTERN_BYTES+1];
	logic [7:0] win_ext [BB];
	logic [7:0] rep_ext [BB];

	logic                ld_valid;
	logic                ld_ready;
	logic [8*BB-1:0]     ld_data;
	logic [BW-1:0]       ld_cnt;
	burst_flags_t        ld_flags;

	// clamp lengths to the configured limits
	assign pl_eff = (pat_len_q > CfgLenW'(MAX_PATTERN_BYTES)) ?
		CW'(MAX_PATTERN_BYTES) : CW'(pat_len_q);
	assign rl_eff = (rep_len_q > CfgLenW'(MAX_REPLACE_BYTES)) ?
		RW'(MAX_REPLACE_BYTES) : RW'(rep_len_q);

	assign accept = in_ch.valid & in_ch.ready;
	assign in_ch.ready = ld_ready;
	assign full  = ((cnt_q + CW'(1)) == pl_eff);
	assign match = mchain[MAX_PATTERN_BYTES];

	// advance the window on each accepted item if the pattern length is nonzero;
	// shift out the oldest byte when full, not matching and the string goes on
	assign ctl.upd   = accept & (pl_eff != '0);
	assign ctl.shift = full & ~match & ~in_ch.in_last;

	assign mchain[0] = 1'b1;

	for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
		logic [7:0] nxt;
		if (i + 1 < MAX_PATTERN_BYTES) begin : g_nb
			assign nxt = cur[i+1];
		end else begin : g_end
			assign nxt = 8'h00;
		end
		sfr_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.wr        (cnt_q == CW'(i)),
			.active    (CW'(i) < pl_eff),
			.new_byte  (in_ch.in_byte),
			.pat_byte  (pat_bytes_q[8*i +: 8]),
			.nxt_byte  (nxt),
			.match_in  (mchain[i]),
			.cur_byte  (cur[i]),
			.match_out (mchain[i+1])
		);
	end

	// widen window and replacement to the burst width
	for (genvar j = 0; j < BB; j++) begin : g_ext
		if (j < MAX_PATTERN_BYTES) begin : g_w
			assign win_ext[j] = cur[j];
		end else begin : g_wz
			assign win_ext[j] = 8'h00;
		end
		if (j < MAX_REPLACE_BYTES) begin : g_r
			assign rep_ext[j] = rep_bytes_q[8*j +: 8];
		end else begin : g_rz
			assign rep_ext[j] = 8'h00;
		end
	end

	// build the burst of results that this item causes
	always_comb begin
		ld_data        = '0;
		ld_cnt         = '0;
		ld_flags.last  = in_ch.in_last;
		ld_flags.empty = 1'b0;
		if (pl_eff == '0) begin
			// pass-through
			ld_data[7:0] = in_ch.in_byte;
			ld_cnt       = BW'(1);
		end else if (full & match) begin
			if (in_ch.in_last & (rl_eff == '0)) begin
				ld_cnt         = BW'(1);
				ld_flags.empty = 1'b1;
			end else begin
				for (int k = 0; k < BB; k++) begin
					ld_data[8*k +: 8] = rep_ext[k];
				end
				ld_cnt = BW'(rl_eff);
			end
		end else if (in_ch.in_last) begin
			// flush the window, new byte included
			for (int k = 0; k < BB; k++) begin
				ld_data[8*k +: 8] = win_ext[k];
			end
			ld_cnt = BW'(cnt_q) + BW'(1);
		end else if (full) begin
			ld_data[7:0] = cur[0];
			ld_cnt       = BW'(1);
		end
	end

	assign ld_valid = accept & (ld_cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_bytes_q <= '0;
			pat_len_q   <= '0;
			rep_bytes_q <= '0;
			rep_len_q   <= '0;
			cnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_PATTERN_BYTES:      pat_bytes_q <= cfg_data;
					CFG_PATTERN_LENGTH:     pat_len_q   <= cfg_data[CfgLenW-1:0];
					CFG_REPLACEMENT_BYTES:  rep_bytes_q <= cfg_data;
					CFG_REPLACEMENT_LENGTH: rep_len_q   <= cfg_data[CfgLenW-1:0];
					default: ;
				endcase
			end
			if (cfg_we & (cfg_idx_t'(cfg_index) == CFG_PATTERN_LENGTH)) begin
				// drop whatever the window holds
				cnt_q <= '0;
			end else if (accept) begin
				if ((pl_eff == '0) | in_ch.in_last | (full & match)) begin
					cnt_q <= '0;
				end else if (!full) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	sfr_emit #(
		.BurstBytes (BB)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld_valid (ld_valid),
		.ld_ready (ld_ready),
		.ld_data  (ld_data),
		.ld_cnt   (ld_cnt),
		.ld_flags (ld_flags),
		.out_ch   (out_ch)
	);

endmodule
